// ===== rtl/assz_pkg.sv =====
// Shared package of the adaptive send-size selector.
// Holds default parameter values, reset constants, register indexes, the
// controller state type and the command and status structs. No dependencies.
package assz_pkg;

    localparam int BLOCK_BYTES_DEF = 4096;
    localparam int BUCKETS_DEF     = 32;
    localparam int AMP_SHIFT_DEF   = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [31:0] DEFAULT_RATE_RST = 32'd1000000;
    localparam logic [4:0]  AVG_SHIFT_RST    = 5'd3;
    localparam logic [15:0] PERIOD_RST       = 16'd64;

    localparam logic [63:0] TICKS_PER_SEC = 64'd10000000;
    localparam logic [63:0] SAT64         = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEFAULT_RATE  = 2'd0,
        REG_AVERAGE_SHIFT = 2'd1,
        REG_REBASE_PERIOD = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CH_INIT,
        OP_CH_STEP,
        OP_CH_OUT,
        OP_UP_MUL0,
        OP_UP_MUL1,
        OP_UP_MAP,
        OP_UP_CMP,
        OP_DIV_FLOOR,
        OP_DIV_SAMPLE,
        OP_DIV_MOD,
        OP_CAP_DONE,
        OP_SMP_DONE,
        OP_BLEND,
        OP_RA_TOT,
        OP_PEAK_SET,
        OP_PEAK_BLEND,
        OP_FLOOR_DONE,
        OP_SWEEP
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CH_INIT,
        ST_CH_SCAN,
        ST_CH_OUT,
        ST_UP_MUL0,
        ST_UP_MUL1,
        ST_UP_MAP,
        ST_UP_CMP,
        ST_CAP_START,
        ST_CAP_WAIT,
        ST_SMP_START,
        ST_SMP_WAIT,
        ST_BLEND,
        ST_CHECK,
        ST_MOD_WAIT,
        ST_RA_TOT,
        ST_RA_PEAK,
        ST_RB_PEAK,
        ST_FL_START,
        ST_FL_WAIT,
        ST_SWEEP
    } ctrl_state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic fast;
        logic scan_go;
        logic out_free;
        logic map_go;
        logic rise;
        logic div_done;
        logic period_zero;
        logic count_eq;
        logic rem_zero;
        logic sweep_last;
    } dp_status_t;

endpackage

// ===== rtl/adaptive_send_size_selector.sv =====
// Top level of the adaptive send-size selector.
// Instantiates assz_ctrl and assz_dpath; uses assz_pkg.
//
// The block works on one transaction at a time. A choose transaction that
// is answered at once goes from acceptance through dispatch and init to
// the output state. One that scans the rate table steps through the
// scanned buckets (up to BUCKETS) in between. A choose transaction stays
// in its output state for as long as an earlier send size still waits in
// the output register. An update transaction runs two multiply steps,
// steps through the buckets while mapping used_size (up to BUCKETS-1)
// and compares. It then makes one or two passes of the shared divider
// (trip-floor cap and sample rate); a pass ends early when the quotient
// saturates. A further division checks for a rebase when the sample count
// is not equal to rebase_period, and a zero rebase_period skips that
// check. A rebase adds one more division and a sweep over all BUCKETS
// entries of the rate table. The output register lets a result wait
// while the next transaction is taken in. Configuration is written
// through a plain write port and must only change while the block is
// idle.
module adaptive_send_size_selector #(
    parameter int BLOCK_BYTES = assz_pkg::BLOCK_BYTES_DEF,
    parameter int BUCKETS     = assz_pkg::BUCKETS_DEF,
    parameter int AMP_SHIFT   = assz_pkg::AMP_SHIFT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_mode,
    input  logic [31:0]                      s_request_size,
    input  logic [31:0]                      s_used_size,
    input  logic [31:0]                      s_bytes_sent,
    input  logic [62:0]                      s_start_time,
    input  logic [62:0]                      s_end_time,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_send_size,
    input  logic                             cfg_wr_en,
    input  logic [assz_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [assz_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);
    import assz_pkg::*;

    // The controller and the datapath meet only through these two structs.
    dp_cmd_t    cmd;
    dp_status_t status;

    assz_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .cmd    (cmd),
        .status (status)
    );

    // The datapath holds the rate table, the estimates, the input latch,
    // the output register and the shared divider.
    assz_dpath #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .BUCKETS    (BUCKETS),
        .AMP_SHIFT  (AMP_SHIFT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_mode        (s_mode),
        .s_request_size(s_request_size),
        .s_used_size   (s_used_size),
        .s_bytes_sent  (s_bytes_sent),
        .s_start_time  (s_start_time),
        .s_end_time    (s_end_time),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_send_size   (m_send_size)
    );

endmodule

// ===== rtl/assz_div.sv =====
// Iterative 128 by 64 bit unsigned divider, one quotient bit per cycle.
// Saturates on a zero divisor or a quotient wider than 64 bits. Uses assz_pkg.
module assz_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] num_hi,
    input  logic [63:0] num_lo,
    input  logic [63:0] den,
    output logic        done,
    output logic [63:0] quot,
    output logic [63:0] rema
);
    import assz_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] rem_reg;
    logic [63:0] lo_reg;
    logic [63:0] q_reg;
    logic [63:0] den_reg;

    logic        carry;
    logic [63:0] shifted;
    logic        take;
    logic [63:0] rem_next;
    logic        sat;

    assign sat      = (den == 64'd0) || (num_hi >= den);
    assign carry    = rem_reg[63];
    assign shifted  = {rem_reg[62:0], lo_reg[63]};
    assign take     = carry || (shifted >= den_reg);
    assign rem_next = take ? (shifted - den_reg) : shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= '0;
                if (sat) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num_hi;
            lo_reg  <= num_lo;
            den_reg <= den;
            q_reg   <= sat ? SAT64 : 64'd0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            lo_reg  <= {lo_reg[62:0], 1'b0};
            q_reg   <= {q_reg[62:0], take};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rema = rem_reg;

endmodule

// ===== rtl/assz_dpath.sv =====
// Datapath of the adaptive send-size selector: configuration, rate table,
// estimates, work registers, output register and the shared divider.
// Uses assz_pkg and assz_div; driven by assz_ctrl through dp_cmd_t.
module assz_dpath #(
    parameter int BLOCK_BYTES = assz_pkg::BLOCK_BYTES_DEF,
    parameter int BUCKETS     = assz_pkg::BUCKETS_DEF,
    parameter int AMP_SHIFT   = assz_pkg::AMP_SHIFT_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  assz_pkg::dp_cmd_t                cmd,
    output assz_pkg::dp_status_t             status,
    input  logic                             s_mode,
    input  logic [31:0]                      s_request_size,
    input  logic [31:0]                      s_used_size,
    input  logic [31:0]                      s_bytes_sent,
    input  logic [62:0]                      s_start_time,
    input  logic [62:0]                      s_end_time,
    input  logic                             cfg_wr_en,
    input  logic [assz_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [assz_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [31:0]                      m_send_size
);
    import assz_pkg::*;

    localparam int AW    = $clog2(BUCKETS);
    localparam int IDX_W = AW + 1;
    localparam int M_W   = 34;
    localparam logic [63:0] BASE_RST  = 64'(DEFAULT_RATE_RST) << AMP_SHIFT;
    localparam logic [63:0] FLOOR_RST = (TICKS_PER_SEC << AMP_SHIFT) / 64'(DEFAULT_RATE_RST);
    localparam logic [63:0] FLOOR_MIN = (64'd1 << AMP_SHIFT) >> 3;
    localparam logic [63:0] TICKS_AMP = TICKS_PER_SEC << AMP_SHIFT;
    localparam logic [M_W-1:0] BLK  = M_W'(BLOCK_BYTES);
    localparam logic [M_W-1:0] MAXS = M_W'(BLOCK_BYTES * BUCKETS);

    function automatic logic [63:0] blend(input logic [63:0] a, input logic [63:0] x,
                                          input logic [4:0] s);
        blend = a - (a >> s) + (x >> s);
    endfunction

    // Configuration and long-lived state.
    logic [31:0] rate_reg;
    logic [4:0]  shift_reg;
    logic [15:0] period_reg;
    logic [63:0] bucket_reg [BUCKETS];
    logic [63:0] total_reg;
    logic [63:0] prev_reg;
    logic [63:0] peak_reg;
    logic [63:0] floor_reg;
    logic [31:0] count_reg;
    logic        m_valid_reg;

    // Work registers of the item in progress.
    logic             mode_reg;
    logic [31:0]      req_reg;
    logic [31:0]      used_reg;
    logic [31:0]      bytes_reg;
    logic [62:0]      t0_reg;
    logic [62:0]      t1_reg;
    logic [62:0]      elapsed_reg;
    logic [63:0]      pp0_reg;
    logic [63:0]      bt_reg;
    logic [95:0]      cost_reg;
    logic [63:0]      diff_reg;
    logic [63:0]      sample_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] best_reg;
    logic [63:0]      best_rate_reg;
    logic [M_W-1:0]   m_reg;
    logic [31:0]      res_reg;
    logic [31:0]      send_reg;
    logic             sweep_blend_reg;

    logic [63:0]    base;
    logic [63:0]    rd;
    logic [M_W-1:0] span_w;
    logic [M_W-1:0] span_c;
    logic [M_W-1:0] size_best;
    logic [31:0]    res_scan;
    logic [31:0]    res_fast;
    logic           req_small;
    logic [62:0]    elapsed_next;
    logic [127:0]   el_amp;
    logic           rise;
    logic [95:0]    cost_sh;
    logic [63:0]    diff_cmp;
    logic [64:0]    floor_up;
    logic [63:0]    floor_up_sat;
    logic [63:0]    floor_dn;
    logic [63:0]    floor_dn_min;
    logic [127:0]   smp_num;
    logic [63:0]    pp1;
    logic [63:0]    ra_tot;
    logic           out_free;

    logic        div_start;
    logic [63:0] div_hi;
    logic [63:0] div_lo;
    logic [63:0] div_den;
    logic        div_done;
    logic [63:0] div_q;
    logic [63:0] div_rem;

    assign base      = 64'(rate_reg) << AMP_SHIFT;
    assign rd        = bucket_reg[idx_reg[AW-1:0]];
    assign span_w    = M_W'(req_reg) + BLK - M_W'(1);
    assign span_c    = (span_w > MAXS) ? MAXS : span_w;
    assign size_best = (M_W'(best_reg) + M_W'(1)) * BLK;
    assign res_scan  = (size_best < M_W'(req_reg)) ? size_best[31:0] : req_reg;
    assign req_small = M_W'(req_reg) <= BLK;
    assign res_fast  = (req_small || (M_W'(req_reg) < MAXS)) ? req_reg : MAXS[31:0];

    assign elapsed_next = (t1_reg >= t0_reg) ? (t1_reg - t0_reg) : 63'd0;
    assign el_amp       = 128'(elapsed_reg) << AMP_SHIFT;
    assign rise         = el_amp > 128'(cost_reg);
    assign cost_sh      = cost_reg >> AMP_SHIFT;
    assign diff_cmp     = (|cost_sh[95:64]) ? SAT64 : cost_sh[63:0];
    assign floor_up     = 65'(floor_reg) + 65'(floor_reg >> 10);
    assign floor_up_sat = floor_up[64] ? SAT64 : floor_up[63:0];
    assign floor_dn     = floor_reg - (floor_reg >> 10);
    assign floor_dn_min = (floor_dn < FLOOR_MIN) ? FLOOR_MIN : floor_dn;
    assign smp_num      = 128'(bt_reg) << AMP_SHIFT;
    assign pp1          = 64'(bytes_reg) * 64'(floor_reg[63:32]);
    assign ra_tot       = total_reg - (total_reg >> 1) + (prev_reg >> 1);
    assign out_free     = !m_valid_reg || m_ready;

    // Operand selection for the shared divider.
    always_comb begin
        div_start = 1'b0;
        div_hi    = 64'd0;
        div_lo    = 64'd0;
        div_den   = 64'd0;
        case (cmd.op)
            OP_DIV_FLOOR: begin
                div_start = 1'b1;
                div_lo    = TICKS_AMP;
                div_den   = peak_reg >> AMP_SHIFT;
            end
            OP_DIV_SAMPLE: begin
                div_start = 1'b1;
                div_hi    = smp_num[127:64];
                div_lo    = smp_num[63:0];
                div_den   = diff_reg;
            end
            OP_DIV_MOD: begin
                div_start = 1'b1;
                div_lo    = 64'(count_reg);
                div_den   = 64'(period_reg);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assz_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num_hi (div_hi),
        .num_lo (div_lo),
        .den    (div_den),
        .done   (div_done),
        .quot   (div_q),
        .rema   (div_rem)
    );

    always_comb begin
        status.mode        = mode_reg;
        status.fast        = req_small || (total_reg > base);
        status.scan_go     = m_reg <= span_c;
        status.out_free    = out_free;
        status.map_go      = (idx_reg < IDX_W'(BUCKETS - 1)) && (m_reg < M_W'(used_reg));
        status.rise        = rise;
        status.div_done    = div_done;
        status.period_zero = period_reg == 16'd0;
        status.count_eq    = count_reg == 32'(period_reg);
        status.rem_zero    = div_rem == 64'd0;
        status.sweep_last  = idx_reg == IDX_W'(BUCKETS - 1);
    end

    // Configuration, estimates and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg    <= DEFAULT_RATE_RST;
            shift_reg   <= AVG_SHIFT_RST;
            period_reg  <= PERIOD_RST;
            for (int i = 0; i < BUCKETS; i++) begin
                bucket_reg[i] <= BASE_RST;
            end
            total_reg   <= BASE_RST;
            prev_reg    <= BASE_RST;
            peak_reg    <= BASE_RST;
            floor_reg   <= FLOOR_RST;
            count_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_DEFAULT_RATE:  rate_reg   <= cfg_wr_data;
                    REG_AVERAGE_SHIFT: shift_reg  <= cfg_wr_data[4:0];
                    REG_REBASE_PERIOD: period_reg <= cfg_wr_data[15:0];
                    default:           rate_reg   <= rate_reg;
                endcase
            end
            if (cmd.op == OP_CH_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_UP_CMP: begin
                    floor_reg <= rise ? floor_up_sat : floor_dn_min;
                end
                OP_CAP_DONE: begin
                    if (div_q < floor_reg) begin
                        floor_reg <= div_q;
                    end
                end
                OP_BLEND: begin
                    bucket_reg[idx_reg[AW-1:0]] <= blend(rd, sample_reg, shift_reg);
                    total_reg <= blend(total_reg, sample_reg, shift_reg);
                    count_reg <= count_reg + 32'd1;
                end
                OP_RA_TOT: begin
                    if (prev_reg > total_reg) begin
                        total_reg <= ra_tot;
                        prev_reg  <= ra_tot;
                        count_reg <= 32'd0;
                    end
                end
                OP_PEAK_SET: begin
                    peak_reg <= total_reg;
                end
                OP_PEAK_BLEND: begin
                    peak_reg <= (peak_reg < total_reg) ? total_reg
                                                       : blend(peak_reg, total_reg, shift_reg);
                end
                OP_FLOOR_DONE: begin
                    floor_reg <= div_q;
                end
                OP_SWEEP: begin
                    bucket_reg[idx_reg[AW-1:0]] <= sweep_blend_reg
                        ? blend(rd, peak_reg, shift_reg) : total_reg;
                end
                default: begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Work registers; they carry no reset.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                mode_reg  <= s_mode;
                req_reg   <= s_request_size;
                used_reg  <= s_used_size;
                bytes_reg <= s_bytes_sent;
                t0_reg    <= s_start_time;
                t1_reg    <= s_end_time;
            end
            OP_CH_INIT: begin
                idx_reg       <= '0;
                best_reg      <= '0;
                best_rate_reg <= bucket_reg[0];
                m_reg         <= BLK;
                res_reg       <= res_fast;
            end
            OP_CH_STEP: begin
                if (m_reg <= span_c) begin
                    if (best_rate_reg <= rd) begin
                        best_reg      <= idx_reg;
                        best_rate_reg <= rd;
                    end
                    if (total_reg == base) begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        m_reg   <= m_reg + BLK;
                    end else begin
                        idx_reg <= {idx_reg[IDX_W-2:0], 1'b1};
                        m_reg   <= {m_reg[M_W-2:0], 1'b0};
                    end
                end else begin
                    res_reg <= res_scan;
                end
            end
            OP_CH_OUT: begin
                if (out_free) begin
                    send_reg <= res_reg;
                end
            end
            OP_UP_MUL0: begin
                elapsed_reg <= elapsed_next;
                pp0_reg     <= 64'(bytes_reg) * 64'(floor_reg[31:0]);
                idx_reg     <= '0;
                m_reg       <= BLK;
            end
            OP_UP_MUL1: begin
                cost_reg <= 96'(pp0_reg) + (96'(pp1) << 32);
                bt_reg   <= 64'(bytes_reg) * TICKS_PER_SEC;
            end
            OP_UP_MAP: begin
                if (status.map_go) begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    m_reg   <= m_reg + BLK;
                end
            end
            OP_UP_CMP: begin
                diff_reg <= rise ? 64'(elapsed_reg) : diff_cmp;
            end
            OP_SMP_DONE: begin
                sample_reg <= div_q;
            end
            OP_PEAK_SET: begin
                sweep_blend_reg <= 1'b0;
            end
            OP_PEAK_BLEND: begin
                sweep_blend_reg <= 1'b1;
            end
            OP_FLOOR_DONE: begin
                idx_reg <= '0;
            end
            OP_SWEEP: begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            default: begin
                res_reg <= res_reg;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_send_size = send_reg;

endmodule

// ===== rtl/assz_ctrl.sv =====
// Controller state machine of the adaptive send-size selector.
// Sequences the datapath through dp_cmd_t and reads dp_status_t. Uses assz_pkg.
module assz_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output assz_pkg::dp_cmd_t    cmd,
    input  assz_pkg::dp_status_t status
);
    import assz_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                state_next = status.mode ? ST_UP_MUL0 : ST_CH_INIT;
            end
            ST_CH_INIT: begin
                cmd.op     = OP_CH_INIT;
                state_next = status.fast ? ST_CH_OUT : ST_CH_SCAN;
            end
            ST_CH_SCAN: begin
                cmd.op = OP_CH_STEP;
                if (!status.scan_go) begin
                    state_next = ST_CH_OUT;
                end
            end
            ST_CH_OUT: begin
                cmd.op = OP_CH_OUT;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_UP_MUL0: begin
                cmd.op     = OP_UP_MUL0;
                state_next = ST_UP_MUL1;
            end
            ST_UP_MUL1: begin
                cmd.op     = OP_UP_MUL1;
                state_next = ST_UP_MAP;
            end
            ST_UP_MAP: begin
                cmd.op = OP_UP_MAP;
                if (!status.map_go) begin
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                cmd.op     = OP_UP_CMP;
                state_next = status.rise ? ST_CAP_START : ST_SMP_START;
            end
            ST_CAP_START: begin
                cmd.op     = OP_DIV_FLOOR;
                state_next = ST_CAP_WAIT;
            end
            ST_CAP_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_CAP_DONE;
                    state_next = ST_SMP_START;
                end
            end
            ST_SMP_START: begin
                cmd.op     = OP_DIV_SAMPLE;
                state_next = ST_SMP_WAIT;
            end
            ST_SMP_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_SMP_DONE;
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND: begin
                cmd.op     = OP_BLEND;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.period_zero) begin
                    state_next = ST_IDLE;
                end else if (status.count_eq) begin
                    state_next = ST_RA_TOT;
                end else begin
                    cmd.op     = OP_DIV_MOD;
                    state_next = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT: begin
                if (status.div_done) begin
                    state_next = status.rem_zero ? ST_RB_PEAK : ST_IDLE;
                end
            end
            ST_RA_TOT: begin
                cmd.op     = OP_RA_TOT;
                state_next = ST_RA_PEAK;
            end
            ST_RA_PEAK: begin
                cmd.op     = OP_PEAK_SET;
                state_next = ST_FL_START;
            end
            ST_RB_PEAK: begin
                cmd.op     = OP_PEAK_BLEND;
                state_next = ST_FL_START;
            end
            ST_FL_START: begin
                cmd.op     = OP_DIV_FLOOR;
                state_next = ST_FL_WAIT;
            end
            ST_FL_WAIT: begin
                if (status.div_done) begin
                    cmd.op     = OP_FLOOR_DONE;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                cmd.op = OP_SWEEP;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/assz_checker.sv =====
// Port-level assertions of the adaptive send-size selector and their bind.
// Depends only on the ports of adaptive_send_size_selector.
module assz_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             s_mode,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [31:0]                      m_send_size
);

    // A waiting result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_send_size)))
        else $error("result changed while stalled");

    // After a transaction is taken, the block is busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice back to back");

    // An update transaction never produces a result right away.
    a_update_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode) |=> !$rose(m_valid))
        else $error("update produced a result");

    // A result is only raised while the block is busy on a transaction.
    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised while idle");

endmodule

bind adaptive_send_size_selector assz_checker u_assz_checker (.*);
